FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the bounding-box block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in next-cycle check");

`endif

FILE: hw/rtl/vnbb_pkg.sv
// Types, constants and helper functions of the volume bounding-box block.
package vnbb_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int COORD_W  = $clog2(MAX_DIM);
   localparam int SIZE_W   = 13;
   localparam int MARGIN_W = 12;
   localparam int EXT_W    = 13;
   localparam int VOXEL_W  = 16;
   localparam int ADDR_W   = 2;

   localparam int RSP_FIELDS_W = 3 * COORD_W + 3 * EXT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [ADDR_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [ADDR_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [ADDR_W-1:0] REG_SIZE_Z = 2'd2;
   localparam logic [ADDR_W-1:0] REG_MARGIN = 2'd3;

   localparam logic [SIZE_W-1:0]   SIZE_X_RESET = 13'd4096;
   localparam logic [SIZE_W-1:0]   SIZE_Y_RESET = 13'd4096;
   localparam logic [SIZE_W-1:0]   SIZE_Z_RESET = 13'd1;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd50;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } tops_type;

   typedef struct packed {
      logic               seen;
      logic [COORD_W-1:0] low_x;
      logic [COORD_W-1:0] low_y;
      logic [COORD_W-1:0] low_z;
      logic [COORD_W-1:0] high_x;
      logic [COORD_W-1:0] high_y;
      logic [COORD_W-1:0] high_z;
   } box_type;

   // Highest valid coordinate for a size register; zero counts as one.
   function automatic logic [COORD_W-1:0] size_top(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = '0;
      end else if (s > SIZE_W'(MAX_DIM)) begin
         r = SIZE_W'(MAX_DIM - 1);
      end else begin
         r = s - SIZE_W'(1);
      end
      return r[COORD_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/vnbb_accum.sv
// Input register, raster position counters and running minimum and maximum.
module vnbb_accum
   import vnbb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [VOXEL_W-1:0] in_value,
   input  tops_type           tops,
   input  logic               box_ready,
   output logic               box_valid,
   output box_type            box
);

   logic               a_valid_ff, a_valid_in;
   logic [VOXEL_W-1:0] a_value_ff;
   logic [COORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [COORD_W-1:0] pos_x_in, pos_y_in, pos_z_in;
   box_type            acc_ff, acc_in;
   box_type            upd;
   logic               end_x, end_y, end_z, last, fire, nz;

   always_comb begin
      nz           = (a_value_ff != '0);
      upd          = acc_ff;
      if (nz) begin
         upd.seen = 1'b1;
         if (pos_x_ff < acc_ff.low_x)  upd.low_x  = pos_x_ff;
         if (pos_y_ff < acc_ff.low_y)  upd.low_y  = pos_y_ff;
         if (pos_z_ff < acc_ff.low_z)  upd.low_z  = pos_z_ff;
         if (pos_x_ff > acc_ff.high_x) upd.high_x = pos_x_ff;
         if (pos_y_ff > acc_ff.high_y) upd.high_y = pos_y_ff;
         if (pos_z_ff > acc_ff.high_z) upd.high_z = pos_z_ff;
      end
      end_x = (pos_x_ff >= tops.x);
      end_y = (pos_y_ff >= tops.y);
      end_z = (pos_z_ff >= tops.z);
      last  = end_x && end_y && end_z;
      fire  = a_valid_ff && (!last || box_ready);

      box_valid = a_valid_ff && last;
      box       = upd;
      in_ready  = !a_valid_ff || fire;
      a_valid_in = in_valid ? 1'b1 : (a_valid_ff && !fire);

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      acc_in   = acc_ff;
      if (fire) begin
         if (last) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
            acc_in   = '{seen: 1'b0, low_x: '1, low_y: '1, low_z: '1,
                         high_x: '0, high_y: '0, high_z: '0};
         end else begin
            acc_in = upd;
            if (!end_x) begin
               pos_x_in = pos_x_ff + COORD_W'(1);
            end else begin
               pos_x_in = '0;
               if (!end_y) begin
                  pos_y_in = pos_y_ff + COORD_W'(1);
               end else begin
                  pos_y_in = '0;
                  pos_z_in = pos_z_ff + COORD_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         acc_ff     <= '{seen: 1'b0, low_x: '1, low_y: '1, low_z: '1,
                         high_x: '0, high_y: '0, high_z: '0};
      end else begin
         a_valid_ff <= a_valid_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         pos_z_ff   <= pos_z_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_value_ff <= in_value;
      end
   end

   `include "assert_macros.svh"

   `ASSERT_NOW(a_box_ordered, clock, reset, acc_ff.seen,
      acc_ff.low_x <= acc_ff.high_x && acc_ff.low_y <= acc_ff.high_y &&
      acc_ff.low_z <= acc_ff.high_z)
   `ASSERT_NEXT(a_rearm_after_last, clock, reset, fire && last,
      pos_x_ff == '0 && pos_y_ff == '0 && pos_z_ff == '0 && !acc_ff.seen)
   `ASSERT_NOW(a_no_box_when_idle, clock, reset, !a_valid_ff, !box_valid)

endmodule

FILE: hw/rtl/vnbb_widen.sv
// Final box register, margin widening with clamping, and the result register.
module vnbb_widen
   import vnbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  box_valid,
   output logic                  box_ready,
   input  box_type               box,
   input  tops_type              tops,
   input  logic [MARGIN_W-1:0]   margin,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   typedef struct packed {
      logic [COORD_W-1:0] corner;
      logic [EXT_W-1:0]   extent;
   } axis_type;

   function automatic axis_type widen_axis(input logic [COORD_W-1:0]  lo,
                                           input logic [COORD_W-1:0]  hi,
                                           input logic [COORD_W-1:0]  top,
                                           input logic [MARGIN_W-1:0] mg);
      logic [COORD_W:0] a;
      logic [COORD_W:0] b;
      axis_type         r;
      a = (lo > mg) ? ({1'b0, lo} - {1'b0, mg}) : '0;
      b = {1'b0, hi} + {1'b0, mg};
      if (a > {1'b0, top}) a = {1'b0, top};
      if (b > {1'b0, top}) b = {1'b0, top};
      r.corner = a[COORD_W-1:0];
      r.extent = EXT_W'(b - a) + EXT_W'(1);
      return r;
   endfunction

   logic               b_valid_ff, b_valid_in;
   box_type            b_box_ff;
   logic               c_valid_ff, c_valid_in;
   logic               c_load;
   axis_type           wx, wy, wz;
   logic [RSP_DATA_W-1:0] data_in;
   logic [RSP_DATA_W-1:0] c_data_ff;
   logic               c_empty_ff;

   always_comb begin
      wx = widen_axis(b_box_ff.low_x, b_box_ff.high_x, tops.x, margin);
      wy = widen_axis(b_box_ff.low_y, b_box_ff.high_y, tops.y, margin);
      wz = widen_axis(b_box_ff.low_z, b_box_ff.high_z, tops.z, margin);
      data_in = '0;
      if (b_box_ff.seen) begin
         data_in[RSP_FIELDS_W-1:0] = {wz.extent, wy.extent, wx.extent,
                                      wz.corner, wy.corner, wx.corner};
      end
      c_load     = b_valid_ff && (!c_valid_ff || rsp_tready);
      box_ready  = !b_valid_ff || c_load;
      b_valid_in = box_valid ? 1'b1 : (b_valid_ff && !c_load);
      c_valid_in = c_load ? 1'b1 : (c_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (box_valid && box_ready) begin
         b_box_ff <= box;
      end
      if (c_load) begin
         c_data_ff  <= data_in;
         c_empty_ff <= !b_box_ff.seen;
      end
   end

   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = c_data_ff;
   assign rsp_tuser  = c_empty_ff;

   `include "assert_macros.svh"

   `ASSERT_NOW(a_empty_zero, clock, reset, c_valid_ff && c_empty_ff, c_data_ff == '0)
   `ASSERT_NOW(a_extent_nonzero, clock, reset, c_valid_ff && !c_empty_ff,
      c_data_ff[3*COORD_W +: EXT_W] != '0 && c_data_ff[3*COORD_W+EXT_W +: EXT_W] != '0 &&
      c_data_ff[3*COORD_W+2*EXT_W +: EXT_W] != '0)
   `ASSERT_NEXT(a_box_moves_on, clock, reset, c_load && !box_valid, !b_valid_ff)

endmodule

FILE: hw/rtl/volume_nonzero_bounding_box.sv
// Top level of the bounding box of nonzero voxels in a 3D volume.
// Voxels arrive on the req_ stream in raster order (x fastest, then y, then z),
// one 16-bit gray level per beat; any nonzero value counts as object.
// A volume ends with the beat at which all three position counters reach the
// last coordinate of their axis. That beat produces exactly one rsp_ beat: the
// lower corner and the extents of the box of nonzero voxels, widened by the
// margin, clamped to the volume. rsp_tuser is high for an all-zero volume, and
// rsp_tdata is then zero. No other beat produces a result.
// The csr_ port writes size_x, size_y, size_z and margin; the user must write
// them only while the block idles, as the block itself does not enforce it. A
// voxel beat is taken every cycle, also while the receiver stalls, unless the
// last beat of a volume waits in the input register because a box and a
// result are both still held. The result passes through the input, box and
// result registers to rsp_tvalid.
// Synchronous reset restores the register defaults, empties the pipeline and
// rearms the counters and the box.
module volume_nonzero_bounding_box
   import vnbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VOXEL_W-1:0]    req_tdata,   // voxel_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // corner_x, corner_y, corner_z, extent_x, extent_y, extent_z, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // empty_res
   input  logic                  csr_we,
   input  logic [ADDR_W-1:0]     csr_addr,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   logic [SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [MARGIN_W-1:0] margin_ff;
   tops_type            tops;
   logic                box_valid, box_ready;
   box_type             box;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_X_RESET;
         size_y_ff <= SIZE_Y_RESET;
         size_z_ff <= SIZE_Z_RESET;
         margin_ff <= MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SIZE_X: begin
               size_x_ff <= csr_wdata;
            end
            REG_SIZE_Y: begin
               size_y_ff <= csr_wdata;
            end
            REG_SIZE_Z: begin
               size_z_ff <= csr_wdata;
            end
            REG_MARGIN: begin
               margin_ff <= csr_wdata[MARGIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tops.x = size_top(size_x_ff);
      tops.y = size_top(size_y_ff);
      tops.z = size_top(size_z_ff);
   end

   vnbb_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata),
      .tops      (tops),
      .box_ready (box_ready),
      .box_valid (box_valid),
      .box       (box)
   );

   vnbb_widen u_widen (
      .clock      (clock),
      .reset      (reset),
      .box_valid  (box_valid),
      .box_ready  (box_ready),
      .box        (box),
      .tops       (tops),
      .margin     (margin_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
